@@ src/swhs_pkg.sv @@
`timescale 1ns / 1ps

package swhs_pkg;

  // Frame geometry
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int MAX_BYTES     = 8;
  localparam int BYTE_IDX_W    = 3;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESP_DELAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_TO_READ = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TIMEOUT  = 3'd5;

  // Register reset values
  localparam logic [15:0] RST_START_LOW     = 16'd18000;
  localparam logic [7:0]  RST_RELEASE_HIGH  = 8'd20;
  localparam logic [7:0]  RST_SAMPLE_DELAY  = 8'd40;
  localparam logic [7:0]  RST_RESP_DELAY    = 8'd80;
  localparam logic [3:0]  RST_BYTES_TO_READ = 4'd5;
  localparam logic [15:0] RST_WAIT_TIMEOUT  = 16'd1000;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_START_LOW     = 4'd1,
    PH_START_HIGH    = 4'd2,
    PH_RESP_FIRST    = 4'd3,
    PH_RESP_SECOND   = 4'd4,
    PH_RESP_WAIT_LOW = 4'd5,
    PH_BIT_WAIT_HIGH = 4'd6,
    PH_BIT_DELAY     = 4'd7,
    PH_BIT_WAIT_LOW  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_RESP_OK  = 2'd1,
    ST_RESP_BAD = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef struct packed {
    logic [15:0] start_low_us;
    logic [7:0]  release_high_us;
    logic [7:0]  sample_delay_us;
    logic [7:0]  response_delay_us;
    logic [3:0]  bytes_to_read;
    logic [15:0] wait_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic op;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    logic [1:0] status;
    logic       busy_res;
  } out_item_t;

endpackage

@@ src/swhs_cfg.sv @@
`timescale 1ns / 1ps

module swhs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [swhs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swhs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output swhs_pkg::cfg_t                   cfg
);

  swhs_pkg::cfg_t cfg_r;
  swhs_pkg::cfg_t cfg_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        swhs_pkg::REG_START_LOW:     cfg_nxt.start_low_us      = cfg_wdata;
        swhs_pkg::REG_RELEASE_HIGH:  cfg_nxt.release_high_us   = cfg_wdata[7:0];
        swhs_pkg::REG_SAMPLE_DELAY:  cfg_nxt.sample_delay_us   = cfg_wdata[7:0];
        swhs_pkg::REG_RESP_DELAY:    cfg_nxt.response_delay_us = cfg_wdata[7:0];
        swhs_pkg::REG_BYTES_TO_READ: cfg_nxt.bytes_to_read     = cfg_wdata[3:0];
        swhs_pkg::REG_WAIT_TIMEOUT:  cfg_nxt.wait_timeout_us   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_us      <= swhs_pkg::RST_START_LOW;
      cfg_r.release_high_us   <= swhs_pkg::RST_RELEASE_HIGH;
      cfg_r.sample_delay_us   <= swhs_pkg::RST_SAMPLE_DELAY;
      cfg_r.response_delay_us <= swhs_pkg::RST_RESP_DELAY;
      cfg_r.bytes_to_read     <= swhs_pkg::RST_BYTES_TO_READ;
      cfg_r.wait_timeout_us   <= swhs_pkg::RST_WAIT_TIMEOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/swhs_core.sv @@
`timescale 1ns / 1ps

module swhs_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  swhs_pkg::in_item_t   item,
  input  swhs_pkg::cfg_t       cfg,
  output swhs_pkg::out_item_t  res
);

  localparam logic [swhs_pkg::BIT_IDX_W-1:0] LAST_BIT =
    swhs_pkg::BIT_IDX_W'(swhs_pkg::BITS_PER_BYTE - 1);

  swhs_pkg::phase_t                   phase_r, phase_nxt;
  logic [15:0]                        timer_r, timer_nxt;
  logic [7:0]                         shift_r, shift_nxt;
  logic [swhs_pkg::BIT_IDX_W-1:0]     bit_r, bit_nxt;
  logic [swhs_pkg::BYTE_IDX_W-1:0]    byte_r, byte_nxt;
  logic                               rok_r, rok_nxt;

  logic [15:0] timer_inc;
  logic [7:0]  shift_smp;
  logic [3:0]  frame;
  logic [3:0]  byte_plus;
  logic        lvl;
  logic        fin_bit, fin_resp, fin_rok;
  logic [7:0]  fin_shift;
  swhs_pkg::status_t ev_status;
  logic        ev_valid, ev_last;
  logic [7:0]  ev_byte;

  assign lvl       = item.line_level;
  assign timer_inc = (timer_r == swhs_pkg::TIMER_MAX) ? timer_r : timer_r + 16'd1;
  assign shift_smp = {shift_r[6:0], lvl};
  assign byte_plus = {1'b0, byte_r} + 4'd1;

  // Clamp frame length to 1..8
  always_comb begin
    if (cfg.bytes_to_read == 4'd0) begin
      frame = 4'd1;
    end else if (cfg.bytes_to_read > 4'(swhs_pkg::MAX_BYTES)) begin
      frame = 4'(swhs_pkg::MAX_BYTES);
    end else begin
      frame = cfg.bytes_to_read;
    end
  end

  // Next state and per-item events
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    rok_nxt   = rok_r;
    fin_bit   = 1'b0;
    fin_resp  = 1'b0;
    fin_rok   = rok_r;
    fin_shift = shift_r;
    ev_status = swhs_pkg::ST_NONE;
    ev_valid  = 1'b0;
    ev_last   = 1'b0;
    ev_byte   = 8'd0;

    case (phase_r)
      swhs_pkg::PH_IDLE: begin
        if (item.op == swhs_pkg::OP_START) begin
          shift_nxt = 8'd0;
          bit_nxt   = '0;
          byte_nxt  = '0;
          rok_nxt   = 1'b0;
          phase_nxt = swhs_pkg::PH_START_LOW;
          timer_nxt = 16'd0;
        end
      end
      swhs_pkg::PH_START_LOW: begin
        timer_nxt = timer_inc;
        if (timer_inc >= cfg.start_low_us) begin
          phase_nxt = swhs_pkg::PH_START_HIGH;
          timer_nxt = 16'd0;
        end
      end
      swhs_pkg::PH_START_HIGH: begin
        timer_nxt = timer_inc;
        if (timer_inc >= {8'd0, cfg.release_high_us}) begin
          phase_nxt = swhs_pkg::PH_RESP_FIRST;
          timer_nxt = 16'd0;
        end
      end
      swhs_pkg::PH_RESP_FIRST: begin
        timer_nxt = timer_inc;
        if (timer_inc >= {8'd0, cfg.sample_delay_us}) begin
          timer_nxt = 16'd0;
          if (!lvl) begin
            phase_nxt = swhs_pkg::PH_RESP_SECOND;
          end else begin
            rok_nxt   = 1'b0;
            phase_nxt = swhs_pkg::PH_RESP_WAIT_LOW;
          end
        end
      end
      swhs_pkg::PH_RESP_SECOND: begin
        timer_nxt = timer_inc;
        if (timer_inc >= {8'd0, cfg.response_delay_us}) begin
          rok_nxt = lvl;
          if (lvl) begin
            phase_nxt = swhs_pkg::PH_RESP_WAIT_LOW;
            timer_nxt = 16'd0;
          end else begin
            fin_resp = 1'b1;
            fin_rok  = 1'b0;
          end
        end
      end
      swhs_pkg::PH_RESP_WAIT_LOW: begin
        if (!lvl) begin
          fin_resp = 1'b1;
        end else begin
          timer_nxt = timer_inc;
          if (timer_inc >= cfg.wait_timeout_us) begin
            ev_status = swhs_pkg::ST_TIMEOUT;
            phase_nxt = swhs_pkg::PH_IDLE;
            timer_nxt = 16'd0;
          end
        end
      end
      swhs_pkg::PH_BIT_WAIT_HIGH: begin
        if (lvl) begin
          phase_nxt = swhs_pkg::PH_BIT_DELAY;
          timer_nxt = 16'd0;
        end else begin
          timer_nxt = timer_inc;
          if (timer_inc >= cfg.wait_timeout_us) begin
            ev_status = swhs_pkg::ST_TIMEOUT;
            phase_nxt = swhs_pkg::PH_IDLE;
            timer_nxt = 16'd0;
          end
        end
      end
      swhs_pkg::PH_BIT_DELAY: begin
        timer_nxt = timer_inc;
        if (timer_inc >= {8'd0, cfg.sample_delay_us}) begin
          shift_nxt = shift_smp;
          if (lvl) begin
            phase_nxt = swhs_pkg::PH_BIT_WAIT_LOW;
            timer_nxt = 16'd0;
          end else begin
            fin_bit   = 1'b1;
            fin_shift = shift_smp;
          end
        end
      end
      swhs_pkg::PH_BIT_WAIT_LOW: begin
        if (!lvl) begin
          fin_bit = 1'b1;
        end else begin
          timer_nxt = timer_inc;
          if (timer_inc >= cfg.wait_timeout_us) begin
            ev_status = swhs_pkg::ST_TIMEOUT;
            phase_nxt = swhs_pkg::PH_IDLE;
            timer_nxt = 16'd0;
          end
        end
      end
      default: begin
        phase_nxt = swhs_pkg::PH_IDLE;
        timer_nxt = 16'd0;
      end
    endcase

    // Response verdict
    if (fin_resp) begin
      timer_nxt = 16'd0;
      if (fin_rok) begin
        ev_status = swhs_pkg::ST_RESP_OK;
        phase_nxt = swhs_pkg::PH_BIT_WAIT_HIGH;
      end else begin
        ev_status = swhs_pkg::ST_RESP_BAD;
        phase_nxt = swhs_pkg::PH_IDLE;
      end
    end

    // Bit done: advance bit/byte counters, emit completed byte
    if (fin_bit) begin
      timer_nxt = 16'd0;
      phase_nxt = swhs_pkg::PH_BIT_WAIT_HIGH;
      if (bit_r >= LAST_BIT) begin
        bit_nxt   = '0;
        ev_valid  = 1'b1;
        ev_byte   = fin_shift;
        shift_nxt = 8'd0;
        if (byte_plus >= frame) begin
          ev_last   = 1'b1;
          byte_nxt  = '0;
          phase_nxt = swhs_pkg::PH_IDLE;
        end else begin
          byte_nxt = byte_plus[swhs_pkg::BYTE_IDX_W-1:0];
        end
      end else begin
        bit_nxt = bit_r + 1'b1;
      end
    end
  end

  // Result fields; line drive follows the phase entered on this item
  always_comb begin
    res.drive_enable = (phase_nxt == swhs_pkg::PH_START_LOW) ||
                       (phase_nxt == swhs_pkg::PH_START_HIGH);
    res.drive_level  = (phase_nxt == swhs_pkg::PH_START_HIGH);
    res.data_byte    = ev_byte;
    res.byte_valid   = ev_valid;
    res.last_byte    = ev_last;
    res.status       = ev_status;
    res.busy_res     = (phase_nxt != swhs_pkg::PH_IDLE);
  end

  // State advances once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= swhs_pkg::PH_IDLE;
      timer_r <= 16'd0;
      shift_r <= 8'd0;
      bit_r   <= '0;
      byte_r  <= '0;
      rok_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      shift_r <= shift_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      rok_r   <= rok_nxt;
    end
  end

  // Checks
  a_last_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.last_byte |-> res.byte_valid)
    else $error("last flag without a byte");

  a_ok_reads_bits: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (res.status == swhs_pkg::ST_RESP_OK)
    |=> (phase_r == swhs_pkg::PH_BIT_WAIT_HIGH) && (timer_r == 16'd0))
    else $error("good response did not start bit reads");

  a_timeout_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (res.status == swhs_pkg::ST_TIMEOUT)
    |=> (phase_r == swhs_pkg::PH_IDLE) && (timer_r == 16'd0))
    else $error("timeout did not return to idle");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.last_byte |=> (phase_r == swhs_pkg::PH_IDLE) && (byte_r == '0))
    else $error("frame end did not return to idle");

endmodule

@@ src/single_wire_humidity_sensor_reader.sv @@
`timescale 1ns / 1ps
// The result of an accepted item is registered and is on out_data in the cycle after acceptance.
// Throughput: one item per cycle unless out_ready stalls the output; the phase sequencer steps once per accepted item.
// The result register is refilled on the same edge it is taken, so out_ready low
// is the only thing that stops input.
// Reset (rst_n low, synchronous): sequencer idle, counters cleared, output empty,
// configuration registers at their default values.
module single_wire_humidity_sensor_reader (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  swhs_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output swhs_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [swhs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [swhs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  swhs_pkg::cfg_t      cfg;
  swhs_pkg::out_item_t res;
  swhs_pkg::out_item_t out_data_r;
  logic                out_valid_r, out_valid_nxt;
  logic                accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  swhs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  swhs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (accept),
    .item    (in_data),
    .cfg     (cfg),
    .res     (res)
  );

  // Output register occupancy
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
